@@ rtl/omms_pkg.sv @@
`default_nettype none
package omms_pkg;
  localparam int CAPACITY = 1024;
  localparam int ID_SPACE = 65536;
  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = 16;
  localparam int LVL_W = 8;
  localparam int KEY_W = LVL_W + ID_W;
  localparam int IDX_W = $clog2(ID_SPACE);

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [ID_W-1:0] item_id;
    logic [LVL_W-1:0] item_level;
    logic want_highest;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic [1:0] status;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/omms_ram.sv @@
`default_nettype none
module omms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/ordered_min_max_set_with_delete.sv @@
// flow: a query reads the sorted store at its head or tail, latches the result, then registers it
//   into the output; add/remove: a level table lookup, a binary search over the sorted store
//   (a read and a compare per probe), then a shift through its port, one moved entry at a time
// throughput: one item at a time; result held in an output register
// reset: count cleared; the per-id level table is swept to zero, one entry at a time,
//   after reset, during which no item is accepted
`default_nettype none
module ordered_min_max_set_with_delete
  import omms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LVL, S_DECIDE, S_SRCH, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_PUT, S_QRD, S_QOUT, S_DONE
  } state_t;

  state_t state_r;
  in_item_t item_r;
  logic [CNT_W-1:0] count_r, lo_r, hi_r, pos_r;
  logic [IDX_W-1:0] clr_r;
  logic [KEY_W-1:0] key_r;
  logic del_r, ins_r;
  logic out_valid_r;
  out_item_t out_r;
  out_item_t res_r;

  // level table
  logic lv_we;
  logic [IDX_W-1:0] lv_waddr, lv_raddr;
  logic [LVL_W-1:0] lv_wdata, lv_rdata;
  // sorted store
  logic st_we;
  logic [POS_W-1:0] st_waddr, st_raddr;
  logic [KEY_W-1:0] st_wdata, st_rdata;

  omms_ram #(.WIDTH(LVL_W), .DEPTH(ID_SPACE)) u_lvl (
    .clk, .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata), .raddr(lv_raddr),
    .rdata(lv_rdata)
  );
  omms_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr),
    .rdata(st_rdata)
  );

  logic [CNT_W-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  always_comb begin
    lv_we = 1'b0;
    lv_waddr = item_r.item_id[IDX_W-1:0];
    lv_wdata = '0;
    lv_raddr = item_r.item_id[IDX_W-1:0];
    st_we = 1'b0;
    st_waddr = pos_r[POS_W-1:0];
    st_wdata = key_r;
    st_raddr = mid[POS_W-1:0];
    case (state_r)
      S_CLEAR: begin
        lv_we = 1'b1;
        lv_waddr = clr_r;
      end
      S_DECIDE: begin
        // remove clears the table entry; add rewrites it at put
        lv_we = (item_r.mode == MODE_REMOVE);
      end
      S_SHIFT_RD: st_raddr = del_r ? POS_W'(pos_r + 1'b1) : POS_W'(pos_r - 1'b1);
      S_SHIFT_WR: begin
        st_we = 1'b1;
        st_wdata = st_rdata;
      end
      S_PUT: begin
        st_we = 1'b1;
        lv_we = 1'b1;
        lv_wdata = item_r.item_level;
      end
      S_QRD: st_raddr = item_r.want_highest ? POS_W'(count_r - 1'b1) : '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(ID_SPACE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          item_r <= in_item;
          case (in_item.mode)
            MODE_ADD, MODE_REMOVE: state_r <= S_LVL;
            MODE_QUERY: state_r <= S_QRD;
            default: state_r <= S_IDLE;
          endcase
        end
        S_LVL: begin
          // level table data ready next cycle
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          lo_r <= '0;
          hi_r <= count_r;
          del_r <= (lv_rdata != '0);
          if (item_r.mode == MODE_ADD && item_r.item_level == '0) begin
            state_r <= S_DONE;
            res_r <= '{found_id: '0, status: STATUS_OK};
          end else if (lv_rdata != '0) begin
            key_r <= {lv_rdata, item_r.item_id};
            ins_r <= (item_r.mode == MODE_ADD);
            state_r <= S_SRCH;
          end else if (item_r.mode == MODE_REMOVE) begin
            state_r <= S_IDLE;
          end else if (count_r >= CNT_W'(CAPACITY)) begin
            res_r <= '{found_id: '0, status: STATUS_FULL};
            state_r <= S_DONE;
          end else begin
            key_r <= {item_r.item_level, item_r.item_id};
            ins_r <= 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_r == hi_r) begin
            if (del_r) pos_r <= lo_r;
            else begin
              pos_r <= count_r;
              hi_r <= lo_r;
            end
            state_r <= S_SHIFT_RD;
          end else state_r <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (st_rdata < key_r) lo_r <= mid + 1'b1;
          else hi_r <= mid;
          state_r <= S_SRCH;
        end
        S_SHIFT_RD: begin
          if (del_r) begin
            if (pos_r >= count_r - 1'b1) begin
              if (pos_r != count_r) count_r <= count_r - 1'b1;
              del_r <= 1'b0;
              if (ins_r) begin
                key_r <= {item_r.item_level, item_r.item_id};
                lo_r <= '0;
                hi_r <= (pos_r != count_r) ? count_r - 1'b1 : count_r;
                state_r <= S_SRCH;
              end else state_r <= S_IDLE;
            end else state_r <= S_SHIFT_WR;
          end else begin
            if (pos_r == hi_r) state_r <= S_PUT;
            else state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          pos_r <= del_r ? pos_r + 1'b1 : pos_r - 1'b1;
          state_r <= S_SHIFT_RD;
        end
        S_PUT: begin
          count_r <= count_r + 1'b1;
          res_r <= '{found_id: '0, status: STATUS_OK};
          state_r <= S_DONE;
        end
        S_QRD: state_r <= S_QOUT;
        S_QOUT: begin
          if (count_r == '0) res_r <= '{found_id: '0, status: STATUS_EMPTY};
          else res_r <= '{found_id: st_rdata[ID_W-1:0], status: STATUS_OK};
          state_r <= S_DONE;
        end
        S_DONE: if (!out_valid_r || !out_stall) begin
          out_r <= res_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("count overflow");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall) else $error("accept during clear");
  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT |=> count_r == $past(count_r) + 1'b1) else $error("put count");
endmodule
`default_nettype wire

@@ test/tb.sv @@
module tb;
  import omms_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  ordered_min_max_set_with_delete dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the ordered set
  logic [KEY_W-1:0] ordered_keys[$];
  logic [LVL_W-1:0] level_of_id[int];
  out_item_t pending_results[$];
  int errors = 0;
  int send_gap_max = 12;
  int stall_max = 12;
  int long_hold_cycles = 0;

  function automatic void drop_id(logic [ID_W-1:0] id);
    logic [KEY_W-1:0] k;
    if (!level_of_id.exists(id)) return;
    k = {level_of_id[id], id};
    foreach (ordered_keys[i])
      if (ordered_keys[i] == k) begin
        ordered_keys.delete(i);
        break;
      end
    level_of_id.delete(id);
  endfunction

  function automatic void place_id(logic [ID_W-1:0] id, logic [LVL_W-1:0] lv);
    logic [KEY_W-1:0] k;
    int pos;
    k = {lv, id};
    pos = ordered_keys.size();
    foreach (ordered_keys[i])
      if (ordered_keys[i] >= k) begin
        pos = i;
        break;
      end
    ordered_keys.insert(pos, k);
    level_of_id[id] = lv;
  endfunction

  // apply one accepted item to the shadow set and queue its result if any
  function automatic void apply_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.mode)
      MODE_ADD: begin
        if (it.item_level != 0) begin
          if (level_of_id.exists(it.item_id)) begin
            drop_id(it.item_id);
            place_id(it.item_id, it.item_level);
          end else if (ordered_keys.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
          end else begin
            place_id(it.item_id, it.item_level);
          end
        end
        pending_results.push_back(r);
      end
      MODE_REMOVE: drop_id(it.item_id);
      MODE_QUERY: begin
        if (ordered_keys.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.found_id = it.want_highest ? ordered_keys[$][ID_W-1:0] : ordered_keys[0][ID_W-1:0];
          r.status = STATUS_OK;
        end
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] mode, logic [ID_W-1:0] id,
                           logic [LVL_W-1:0] lv, logic hi);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = '{mode: mode, item_id: id, item_level: lv, want_highest: hi};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    apply_item(in_item);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: stall a random number of cycles before each item
  initial begin
    int k;
    forever begin
      k = $urandom_range(0, stall_max);
      if (long_hold_cycles > 0) begin
        k = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (k > 0) begin
        out_stall = 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: found_id %h status %0d", $time,
                 out_item.found_id, out_item.status);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item.found_id !== want.found_id) begin
          errors++;
          $display("%0t found_id: expected %h actual %h", $time, want.found_id,
                   out_item.found_id);
        end
        if (out_item.status !== want.status) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, want.status,
                   out_item.status);
        end
      end
    end
  end

  task automatic test_empty_set();
    send_item(MODE_QUERY, 16'h0000, 8'h00, 1'b0);
    send_item(MODE_QUERY, 16'hffff, 8'hff, 1'b1);
    send_item(MODE_REMOVE, 16'h1234, 8'h00, 1'b0);
    send_item(MODE_UNUSED, 16'hffff, 8'hff, 1'b1);
    send_item(MODE_ADD, 16'h0042, 8'h00, 1'b0);
    send_item(MODE_QUERY, 16'h0000, 8'h00, 1'b1);
  endtask

  task automatic test_extremes();
    int rid;
    send_item(MODE_ADD, 16'h0000, 8'd1, 1'b0);
    send_item(MODE_ADD, 16'hffff, 8'd255, 1'b1);
    send_item(MODE_ADD, 16'haaaa, 8'h55, 1'b0);
    send_item(MODE_ADD, 16'h5555, 8'haa, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
    // same level, order falls to the id
    send_item(MODE_ADD, 16'h0001, 8'd1, 1'b0);
    send_item(MODE_ADD, 16'hfffe, 8'd255, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
    // re-add moves an entry
    send_item(MODE_ADD, 16'h0000, 8'd255, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
    send_item(MODE_REMOVE, 16'h0000, 8'h0, 1'b0);
    send_item(MODE_REMOVE, 16'h0000, 8'h0, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
    while (level_of_id.first(rid)) send_item(MODE_REMOVE, rid[ID_W-1:0], 8'h0, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b0);
  endtask

  task automatic test_full_set();
    int i;
    send_gap_max = 0;
    stall_max = 0;
    // ascending keys keep each insert at the tail
    for (i = 0; i < CAPACITY; i++)
      send_item(MODE_ADD, 16'(i * 61 + 7), 8'(1 + i / 5), 1'b0);
    send_gap_max = 12;
    stall_max = 12;
    send_item(MODE_ADD, 16'hfff0, 8'd200, 1'b0);
    send_item(MODE_ADD, 16'(7), 8'd255, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
    send_item(MODE_REMOVE, 16'(68), 8'h0, 1'b0);
    send_item(MODE_ADD, 16'hfff0, 8'd200, 1'b0);
    send_item(MODE_ADD, 16'hfff1, 8'd200, 1'b0);
    send_item(MODE_QUERY, 16'h0, 8'h0, 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    wait_drained();
    long_hold_cycles = 400;
    send_gap_max = 0;
    send_item(MODE_ADD, 16'h0100, 8'd9, 1'b0);
    for (i = 0; i < 20; i++) send_item(MODE_QUERY, 16'h0, 8'h0, i[0]);
    send_gap_max = 12;
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    int sent;
    int m;
    logic [ID_W-1:0] id;
    logic [LVL_W-1:0] lv;
    sent = 0;
    while (sent < count) begin
      if (sent % 200 == 0) begin
        // every 200 items, choose at random between busy stretches and idling ones
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      end
      m = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63) * 1021);
      lv = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      if (m < 40) send_item(MODE_ADD, id, lv, 1'($urandom));
      else if (m < 65) begin
        // often take out an id that is held
        if (ordered_keys.size() != 0 && $urandom_range(0, 1) == 0)
          id = ordered_keys[$urandom_range(0, ordered_keys.size() - 1)][ID_W-1:0];
        send_item(MODE_REMOVE, id, 8'($urandom), 1'($urandom));
      end
      else if (m < 95) send_item(MODE_QUERY, id, 8'($urandom), 1'($urandom));
      else send_item(MODE_UNUSED, id, lv, 1'($urandom));
      if (m < 95) sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_set();
    test_extremes();
    test_full_set();
    test_backpressure();
    test_random_mix(600);
    wait_drained();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #400000000;
    $display("tb: errors");
    $finish;
  end
endmodule

@@ ordered_min_max_set_with_delete.f @@
rtl/omms_pkg.sv
rtl/omms_ram.sv
rtl/ordered_min_max_set_with_delete.sv
test/tb.sv
